[rtl/core/bls_pkg.sv]
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

  // Width of the image size registers on the configuration port.
  localparam int CFG_WIDTH = 13;
  localparam int CFG_INDEX_WIDTH = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Image size after reset.
  localparam logic [CFG_WIDTH-1:0] IMAGE_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_WIDTH-1:0] IMAGE_HEIGHT_RESET = 13'd480;

  // Input beat kinds.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Octant of a line; octant zero has the column rising fastest and the row
  // rising no faster.
  typedef enum logic [2:0] {
    OCT0 = 3'd0,
    OCT1 = 3'd1,
    OCT2 = 3'd2,
    OCT3 = 3'd3,
    OCT4 = 3'd4,
    OCT5 = 3'd5,
    OCT6 = 3'd6,
    OCT7 = 3'd7
  } octant_t;

endpackage

[rtl/core/bls_line_setup.sv]
// Load-time setup: octant choice, mirroring into octant zero, initial error.
module bls_line_setup
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        start_col,
  input  logic [COORD_BITS-1:0]        start_row,
  input  logic [COORD_BITS-1:0]        end_col,
  input  logic [COORD_BITS-1:0]        end_row,
  output octant_t                      octant,
  output logic signed [COORD_BITS:0]   major_start,
  output logic signed [COORD_BITS:0]   major_stop,
  output logic signed [COORD_BITS:0]   minor_start,
  output logic signed [COORD_BITS:0]   major_delta,
  output logic signed [COORD_BITS:0]   minor_delta,
  output logic signed [COORD_BITS+2:0] decision_init
);

  localparam int P = COORD_BITS + 1;

  // Mirror a point (u, v) into octant zero; the result is {a, b}.
  function automatic logic [2*P-1:0] into_zero(input octant_t oct,
                                               input logic signed [P-1:0] u,
                                               input logic signed [P-1:0] v);
    logic signed [P-1:0] a;
    logic signed [P-1:0] b;
    begin
      unique case (oct)
        OCT0: begin a = u;  b = v;  end
        OCT1: begin a = v;  b = u;  end
        OCT2: begin a = v;  b = -u; end
        OCT3: begin a = -u; b = v;  end
        OCT4: begin a = -u; b = -v; end
        OCT5: begin a = -v; b = -u; end
        OCT6: begin a = -v; b = u;  end
        default: begin a = u; b = -v; end
      endcase
      into_zero = {a, b};
    end
  endfunction

  logic signed [P-1:0] c1, r1, c2, r2;
  logic signed [P-1:0] dx, dy, ndx, ndy;
  logic [2*P-1:0] p1, p2;
  logic signed [P-1:0] a1, b1, a2, b2;

  assign c1 = $signed({1'b0, start_col});
  assign r1 = $signed({1'b0, start_row});
  assign c2 = $signed({1'b0, end_col});
  assign r2 = $signed({1'b0, end_row});

  assign dx  = c2 - c1;
  assign dy  = r2 - r1;
  assign ndx = -dx;
  assign ndy = -dy;

  always_comb begin
    if (!dx[P-1] && !dy[P-1]) begin
      octant = (dy >= dx) ? OCT1 : OCT0;
    end else if (dx[P-1] && !dy[P-1]) begin
      octant = (ndx >= dy) ? OCT3 : OCT2;
    end else if (dx[P-1] && dy[P-1]) begin
      octant = (dy <= dx) ? OCT5 : OCT4;
    end else begin
      octant = (dx >= ndy) ? OCT7 : OCT6;
    end
  end

  assign p1 = into_zero(octant, c1, r1);
  assign p2 = into_zero(octant, c2, r2);
  assign a1 = $signed(p1[2*P-1:P]);
  assign b1 = $signed(p1[P-1:0]);
  assign a2 = $signed(p2[2*P-1:P]);
  assign b2 = $signed(p2[P-1:0]);

  assign major_start = a1;
  assign major_stop  = a2;
  assign minor_start = b1;
  assign major_delta = a2 - a1;
  assign minor_delta = b2 - b1;

  // 2*dy - dx, both deltas non-negative in octant zero.
  assign decision_init = $signed({minor_delta[P-1], minor_delta, 1'b0})
                       - $signed({{2{major_delta[P-1]}}, major_delta});

endmodule

[rtl/core/bresenham_line_stepper.sv]
// Top level of the Bresenham line stepper: input stage, stepping state, result register.
//
//   Channel  Signals                              Beat contents
//   -------  -----------------------------------  -------------------------------------------
//   s_*      s_tvalid s_tready s_tdata s_tuser     tuser: func; tdata: endpoints of a line
//   m_*      m_tvalid m_tready m_tdata m_tlast     tdata: pixel row and column; tlast: last pixel
//   cfg_*    cfg_we cfg_index cfg_data             image width (index 0), image height (index 1)
//
// Every input beat is held in the input register and, if it produces a pixel, passes on into
// the result register; the block takes one beat per clock while the output is not stalled.
// The stepping state is updated as a step beat leaves the input register, so consecutive step
// beats chain without bubbles.
// Reset (rst, synchronous) empties both registers, clears the line state so no line is active,
// and sets the image size to 640 by 480.
// A stalled result holds the result register; the input register still accepts one more beat,
// and s_tready drops only while both registers are full and m_tready is low.
//
// A load beat (func 0) mirrors the line into octant zero and gives no pixel. A step beat
// (func 1) emits the current pixel, mapped back and clamped to the image, then advances one
// pixel along the major axis; the error term steps the minor axis when it is not negative.
// A step with no active line is consumed and gives nothing.
module bresenham_line_stepper
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // From bit 0: start_col, start_row, end_col, end_row, then zero padding.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // Bit 0: func.
  input  logic                                   s_tuser,
  // Output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // From bit 0: pixel_row, pixel_col, then zero padding.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
  output logic                                   m_tlast,
  // Configuration writes
  input  logic                                   cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]             cfg_index,
  input  logic [CFG_WIDTH-1:0]                   cfg_data
);

  localparam int C      = COORD_BITS;
  localparam int P      = COORD_BITS + 1;
  localparam int E      = COORD_BITS + 3;
  localparam int OUT_W  = ((2*COORD_BITS+7)/8)*8;
  localparam int CMP_W  = (C > CFG_WIDTH) ? C : CFG_WIDTH;

  // Configuration registers.
  logic [CFG_WIDTH-1:0] image_width;
  logic [CFG_WIDTH-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic           in_vld;
  logic           in_func;
  logic [C-1:0]   in_start_col, in_start_row, in_end_col, in_end_row;
  logic           advance;
  logic           s_accept;

  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_accept) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_func      <= s_tuser;
      in_start_col <= s_tdata[C-1:0];
      in_start_row <= s_tdata[2*C-1:C];
      in_end_col   <= s_tdata[3*C-1:2*C];
      in_end_row   <= s_tdata[4*C-1:3*C];
    end
  end

  // Load-time setup from the buffered endpoints.
  octant_t             setup_octant;
  logic signed [P-1:0] setup_major_start, setup_major_stop, setup_minor_start;
  logic signed [P-1:0] setup_major_delta, setup_minor_delta;
  logic signed [E-1:0] setup_err;

  bls_line_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_col     (in_start_col),
    .start_row     (in_start_row),
    .end_col       (in_end_col),
    .end_row       (in_end_row),
    .octant        (setup_octant),
    .major_start   (setup_major_start),
    .major_stop    (setup_major_stop),
    .minor_start   (setup_minor_start),
    .major_delta   (setup_major_delta),
    .minor_delta   (setup_minor_delta),
    .decision_init (setup_err)
  );

  // Line state, kept in octant-zero coordinates.
  octant_t             octant_sel;
  logic signed [P-1:0] major_pos, major_end, minor_pos;
  logic signed [P-1:0] major_delta, minor_delta;
  logic signed [E-1:0] decision_err;
  logic                line_active;

  // Map an octant-zero point back into image space; the result is {col, row}.
  function automatic logic [2*P-1:0] out_of_zero(input octant_t oct,
                                                 input logic signed [P-1:0] a,
                                                 input logic signed [P-1:0] b);
    logic signed [P-1:0] u;
    logic signed [P-1:0] v;
    begin
      unique case (oct)
        OCT0: begin u = a;  v = b;  end
        OCT1: begin u = b;  v = a;  end
        OCT2: begin u = -b; v = a;  end
        OCT3: begin u = -a; v = b;  end
        OCT4: begin u = -a; v = -b; end
        OCT5: begin u = -b; v = -a; end
        OCT6: begin u = b;  v = -a; end
        default: begin u = a; v = -b; end
      endcase
      out_of_zero = {u, v};
    end
  endfunction

  // Clamp a coordinate to [0, dim-1]; a zero size clamps to 0.
  function automatic logic [C-1:0] clamp_coord(input logic signed [P-1:0] c,
                                               input logic [CFG_WIDTH-1:0] dim);
    logic [CFG_WIDTH-1:0] lim;
    logic [CMP_W-1:0]     c_ext;
    logic [CMP_W-1:0]     lim_ext;
    logic [CMP_W-1:0]     r;
    begin
      lim     = (dim == '0) ? '0 : dim - 1'b1;
      c_ext   = CMP_W'(c[P-2:0]);
      lim_ext = CMP_W'(lim);
      if (c[P-1]) begin
        r = '0;
      end else if (c_ext > lim_ext) begin
        r = lim_ext;
      end else begin
        r = c_ext;
      end
      clamp_coord = r[C-1:0];
    end
  endfunction

  logic [2*P-1:0]      img_point;
  logic signed [P-1:0] img_col, img_row;
  logic                is_last;
  logic                do_step;
  logic                do_load;
  logic                err_ge;
  logic signed [E-1:0] major_twice, minor_twice;
  logic signed [E-1:0] err_next;

  assign img_point = out_of_zero(octant_sel, major_pos, minor_pos);
  assign img_col   = $signed(img_point[2*P-1:P]);
  assign img_row   = $signed(img_point[P-1:0]);
  assign is_last   = (major_pos >= major_end);

  assign do_load = advance && (in_func == FUNC_LOAD);
  assign do_step = advance && (in_func == FUNC_STEP) && line_active;

  assign err_ge      = !decision_err[E-1];
  assign major_twice = $signed({major_delta[P-1], major_delta, 1'b0});
  assign minor_twice = $signed({minor_delta[P-1], minor_delta, 1'b0});
  assign err_next    = (err_ge ? decision_err - major_twice : decision_err) + minor_twice;

  always_ff @(posedge clk) begin
    if (rst) begin
      octant_sel   <= OCT0;
      major_pos    <= '0;
      major_end    <= '0;
      minor_pos    <= '0;
      major_delta  <= '0;
      minor_delta  <= '0;
      decision_err <= '0;
      line_active  <= 1'b0;
    end else if (do_load) begin
      octant_sel   <= setup_octant;
      major_pos    <= setup_major_start;
      major_end    <= setup_major_stop;
      minor_pos    <= setup_minor_start;
      major_delta  <= setup_major_delta;
      minor_delta  <= setup_minor_delta;
      decision_err <= setup_err;
      line_active  <= 1'b1;
    end else if (do_step) begin
      major_pos    <= major_pos + 1'b1;
      if (err_ge) begin
        minor_pos <= minor_pos + 1'b1;
      end
      decision_err <= err_next;
      if (is_last) begin
        line_active <= 1'b0;
      end
    end
  end

  // Result register.
  logic [C-1:0] pixel_row, pixel_col;
  logic         last_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= do_step;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      pixel_row  <= clamp_coord(img_row, image_height);
      pixel_col  <= clamp_coord(img_col, image_width);
      last_pixel <= is_last;
    end
  end

  assign m_tdata = OUT_W'({pixel_col, pixel_row});
  assign m_tlast = last_pixel;

endmodule

[sim/line_check_pkg.sv]
`timescale 1ns / 100ps
// Pixel predictor and in-order scoreboard for the Bresenham line stepper testbench.
package line_check_pkg;
  import bls_pkg::*;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
  } pixel_t;

  class pixel_scoreboard;
    logic [CFG_WIDTH-1:0] img_w;
    logic [CFG_WIDTH-1:0] img_h;
    octant_t              oct;
    logic signed [12:0]   major_pos;
    logic signed [12:0]   major_end;
    logic signed [12:0]   minor_pos;
    logic signed [12:0]   major_delta;
    logic signed [12:0]   minor_delta;
    logic signed [14:0]   decision_err;
    bit                   line_active;
    pixel_t               pixels_due[$];
    int                   errors;
    int                   live_beats;

    function new();
      img_w        = IMAGE_WIDTH_RESET;
      img_h        = IMAGE_HEIGHT_RESET;
      oct          = OCT0;
      major_pos    = '0;
      major_end    = '0;
      minor_pos    = '0;
      major_delta  = '0;
      minor_delta  = '0;
      decision_err = '0;
      line_active  = 1'b0;
      errors       = 0;
      live_beats   = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  img_w = value;
        REG_IMAGE_HEIGHT: img_h = value;
        default: ;
      endcase
    endfunction

    function octant_t octant_of(int dx, int dy);
      if (dx >= 0 && dy >= 0) begin
        if (dy >= dx) return OCT1;
        return OCT0;
      end
      if (dx < 0 && dy >= 0) begin
        if (-dx >= dy) return OCT3;
        return OCT2;
      end
      if (dx < 0 && dy < 0) begin
        if (dy <= dx) return OCT5;
        return OCT4;
      end
      if (dx >= -dy) return OCT7;
      return OCT6;
    endfunction

    function void to_octant0(octant_t o, int u, int v, output int a, output int b);
      case (o)
        OCT0: begin a = u;  b = v;  end
        OCT1: begin a = v;  b = u;  end
        OCT2: begin a = v;  b = -u; end
        OCT3: begin a = -u; b = v;  end
        OCT4: begin a = -u; b = -v; end
        OCT5: begin a = -v; b = -u; end
        OCT6: begin a = -v; b = u;  end
        default: begin a = u; b = -v; end
      endcase
    endfunction

    function void from_octant0(octant_t o, int a, int b, output int u, output int v);
      case (o)
        OCT0: begin u = a;  v = b;  end
        OCT1: begin u = b;  v = a;  end
        OCT2: begin u = -b; v = a;  end
        OCT3: begin u = -a; v = b;  end
        OCT4: begin u = -a; v = -b; end
        OCT5: begin u = -b; v = -a; end
        OCT6: begin u = b;  v = -a; end
        default: begin u = a; v = -b; end
      endcase
    endfunction

    // A size of zero pins the coordinate to zero.
    function logic [11:0] clamp_to(int c, logic [CFG_WIDTH-1:0] dim);
      int lim;
      lim = (dim == 0) ? 0 : int'(dim) - 1;
      if (c < 0) return 12'd0;
      if (c > lim) return 12'(lim);
      return 12'(c);
    endfunction

    // Returns 1 when the beat loaded a line or produced a pixel.
    function bit note_beat(logic func, logic [11:0] sc, logic [11:0] sr,
                           logic [11:0] ec, logic [11:0] er);
      int     a1, b1, a2, b2, col, row;
      pixel_t px;
      if (func == FUNC_LOAD) begin
        oct = octant_of(int'(ec) - int'(sc), int'(er) - int'(sr));
        to_octant0(oct, int'(sc), int'(sr), a1, b1);
        to_octant0(oct, int'(ec), int'(er), a2, b2);
        major_pos    = 13'(a1);
        major_end    = 13'(a2);
        minor_pos    = 13'(b1);
        major_delta  = 13'(a2 - a1);
        minor_delta  = 13'(b2 - b1);
        decision_err = 15'(2 * (b2 - b1) - (a2 - a1));
        line_active  = 1'b1;
        live_beats++;
        return 1'b1;
      end
      if (!line_active) return 1'b0;
      px.last = (major_pos >= major_end);
      from_octant0(oct, int'(major_pos), int'(minor_pos), col, row);
      px.row = clamp_to(row, img_h);
      px.col = clamp_to(col, img_w);
      pixels_due.insert(pixels_due.size(), px);
      if (decision_err >= 0) begin
        minor_pos    = 13'(int'(minor_pos) + 1);
        decision_err = 15'(int'(decision_err) - 2 * int'(major_delta));
      end
      decision_err = 15'(int'(decision_err) + 2 * int'(minor_delta));
      major_pos    = 13'(int'(major_pos) + 1);
      if (px.last) line_active = 1'b0;
      live_beats++;
      return 1'b1;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_pixel(logic [11:0] row, logic [11:0] col, logic last);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel row %0d col %0d last %0d with none outstanding", row, col, last));
        return;
      end
      want = pixels_due.pop_front();
      if (row !== want.row)
        report($sformatf("row %0d, predicted %0d", row, want.row));
      if (col !== want.col)
        report($sformatf("col %0d, predicted %0d", col, want.col));
      if (last !== want.last)
        report($sformatf("last flag %0d, predicted %0d at row %0d col %0d",
                         last, want.last, want.row, want.col));
    endtask

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

endpackage

[sim/bresenham_line_stepper_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Bresenham line stepper: stimulus, handshakes and checks.
module bresenham_line_stepper_tb;
  import bls_pkg::*;
  import line_check_pkg::*;

  localparam int COORD_BITS      = 12;
  localparam int CYCLE_LIMIT     = 300000;
  // Length of the one long receiver hold-off, in cycles.
  localparam int LONG_HOLD       = 400;
  // Live beats (loads plus pixel-producing steps) in each random phase.
  localparam int BEATS_PER_PHASE = 125;
  localparam int PHASES          = 6;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_TOGGLE,
    READY_RARELY
  } ready_pattern_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  // From bit 0: start_col, start_row, end_col, end_row.
  logic [47:0]                s_tdata = '0;
  // Bit 0: func.
  logic                       s_tuser = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  // From bit 0: pixel_row, pixel_col.
  logic [23:0]                m_tdata;
  logic                       m_tlast;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;

  pixel_scoreboard board;
  int burst_left = 0;
  int cycles = 0;
  bit hold_asked = 1'b0;
  bit hold_done = 1'b0;

  bresenham_line_stepper #(.COORD_BITS(COORD_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog. A correct run takes a small fraction of this limit, even with every beat
  // hitting the longest sender gap and the slowest receiver pattern.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // All block inputs change only through nonblocking assignments, so the values read here
  // are the ones that were stable before the edge. An output beat is taken whenever valid
  // and ready were both high.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_pixel(m_tdata[11:0], m_tdata[23:12], m_tlast);
  end

  // Receiver. It cycles through stall patterns of random length, including stretches of
  // full throughput. Once the stimulus asks for it, it holds ready low for a long stretch
  // while the sender keeps offering beats, so both internal registers fill and the input
  // side has to stall.
  initial begin : receiver
    ready_pattern_t pattern;
    int             len;
    forever begin
      if (hold_asked && !hold_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      pattern = ready_pattern_t'($urandom_range(0, 3));
      len     = $urandom_range(4, 60);
      repeat (len) begin
        case (pattern)
          READY_ALWAYS: m_tready <= 1'b1;
          READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
          READY_TOGGLE: m_tready <= ~m_tready;
          default:      m_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offers one input beat and returns at the edge where it is accepted. The sender works
  // in bursts: between bursts valid may drop for a random gap, and now and then a burst is
  // long enough to give a stretch with no idling at all. Valid is left high after the
  // beat, so back-to-back beats inside a burst never see it drop.
  task automatic send_beat(logic func, logic [11:0] sc, logic [11:0] sr,
                           logic [11:0] ec, logic [11:0] er);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {er, ec, sr, sc};
    do @(posedge clk); while (!s_tready);
    void'(board.note_beat(func, sc, sr, ec, er));
  endtask

  task automatic load_line(logic [11:0] sc, logic [11:0] sr, logic [11:0] ec, logic [11:0] er);
    send_beat(FUNC_LOAD, sc, sr, ec, er);
  endtask

  // Step beats carry random endpoint bits; the block has to ignore them.
  task automatic step_pixels(int n);
    repeat (n)
      send_beat(FUNC_STEP, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  // Drops valid and waits until every predicted pixel has come out. A trailing load or an
  // ignored step may still sit in the pipeline, so the task idles on after that before the
  // image size may change.
  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both size registers on consecutive edges; write enable stays high between them.
  task automatic write_size(logic [CFG_WIDTH-1:0] w, logic [CFG_WIDTH-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    board.set_register(REG_IMAGE_WIDTH, w);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    board.set_register(REG_IMAGE_HEIGHT, h);
    cfg_we    <= 1'b0;
  endtask

  // Moves a coordinate by up to span in either direction, pinned to the coordinate range.
  function automatic logic [11:0] nudge(logic [11:0] p, int span);
    int q;
    q = int'(p) + int'($urandom_range(0, 2 * span)) - span;
    if (q < 0) q = 0;
    if (q > 4095) q = 4095;
    return 12'(q);
  endfunction

  // Random traffic. Most of it is whole lines: a load followed by enough steps to reach
  // the last pixel and up to two steps past it. Some lines are cut short so the next load
  // replaces an active line, and a few span the whole coordinate range (only their first
  // pixels are stepped). The rest is noise: beats of either kind with random contents,
  // and short runs of steps that often find no active line.
  task automatic random_lines(int beats);
    int          goal, pick, r, span, n, steps, ddx, ddy;
    logic [11:0] sc, sr, ec, er;
    goal = board.live_beats + beats;
    while (board.live_beats < goal) begin
      if (!hold_asked && board.live_beats >= 350) hold_asked = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        r    = $urandom_range(0, 99);
        span = (r < 85) ? $urandom_range(0, 12) : (r < 97) ? $urandom_range(13, 60) : 4095;
        sc   = 12'($urandom);
        sr   = 12'($urandom);
        ec   = nudge(sc, span);
        er   = nudge(sr, span);
        load_line(sc, sr, ec, er);
        ddx = int'(ec) - int'(sc);
        ddy = int'(er) - int'(sr);
        if (ddx < 0) ddx = -ddx;
        if (ddy < 0) ddy = -ddy;
        n = ((ddx > ddy) ? ddx : ddy) + 1;
        if ($urandom_range(0, 6) == 0)
          steps = $urandom_range(0, n - 1);
        else
          steps = n + $urandom_range(0, 2);
        if (steps > 40) steps = 40;
        step_pixels(steps);
      end else if (pick < 90) begin
        send_beat(1'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
      end else begin
        step_pixels($urandom_range(1, 3));
      end
    end
  endtask

  initial begin : stimulus
    int                   phase_w[PHASES] = '{4096, 1, 0, 8191, 37, 0};
    int                   phase_h[PHASES] = '{4096, 1, 8191, 0, 2900, 0};
    logic [CFG_WIDTH-1:0] w, h;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the image size left at its reset value of 640 by 480.
    // A step before any line has been loaded gives nothing.
    step_pixels(1);
    // Single-point line at the far corner: one pixel, clamped to the image and flagged
    // last; the step after it finds no line.
    load_line(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    step_pixels(2);
    // Full-range diagonal, then a load that replaces it while it is still active.
    load_line(12'd0, 12'd0, 12'd4095, 12'd4095);
    step_pixels(2);
    load_line(12'd0, 12'd4095, 12'd4095, 12'd0);
    step_pixels(2);
    // Shallow line running right to left.
    load_line(12'd4095, 12'd0, 12'd0, 12'd2);
    step_pixels(1);
    // Steep line going up; six pixels and one step past the end.
    load_line(12'd10, 12'd10, 12'd12, 12'd5);
    step_pixels(7);
    // Short shallow line to the left, stepped exactly to its last pixel.
    load_line(12'd3, 12'd7, 12'd0, 12'd8);
    step_pixels(4);
    settle();

    // Random phases, each with its own image size. The extremes are covered: the largest
    // legal size, one pixel, zero (that coordinate pinned to zero) and the all-ones register.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        w = CFG_WIDTH'($urandom_range(1, 4096));
        h = CFG_WIDTH'($urandom_range(1, 4096));
      end else begin
        w = CFG_WIDTH'(phase_w[p]);
        h = CFG_WIDTH'(phase_h[p]);
      end
      write_size(w, h);
      random_lines(BEATS_PER_PHASE);
      settle();
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/core/bls_pkg.sv
rtl/core/bls_line_setup.sv
rtl/core/bresenham_line_stepper.sv
sim/line_check_pkg.sv
sim/bresenham_line_stepper_tb.sv
